// File: design/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared widths, sector codes and the beat record handed along the cell chain
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 6;

    localparam int CHAN_W  = CHANNEL_BITS;
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 16;

    // stream packing
    localparam int IN_FIELDS_W  = 3 * CHAN_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = HUE_W + SAT_W + CHAN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 1;

    // hue scaling
    localparam int SECTOR_DEG    = 60;
    localparam int SECTOR_UNITS  = SECTOR_DEG * (1 << HUE_FRACTION_BITS);
    localparam int FULL_TURN     = 6 * SECTOR_UNITS;
    localparam int GRAY_FACTOR   = 10000;
    localparam int CHAN_MAX      = (1 << CHANNEL_BITS) - 1;
    localparam int GRAY_LIMIT    = (CHAN_MAX + GRAY_FACTOR - 1) / GRAY_FACTOR;

    // one quotient bit per cell: saturation needs SAT_W + 1 bits
    localparam int NUM_CELLS     = SAT_W + 1;
    localparam int Q_W           = NUM_CELLS;
    localparam int SREM_W        = CHAN_W + 1;
    // integer part of 60 * a / delta is below 64
    localparam int HUE_INT_BITS  = 6;
    localparam int HUE_EXTRA     = NUM_CELLS - HUE_INT_BITS - HUE_FRACTION_BITS;
    localparam int HQ_W          = Q_W - HUE_EXTRA;
    localparam int HDIV_W        = CHAN_W + HUE_INT_BITS - 1;
    localparam int HREM_W        = CHAN_W + HUE_INT_BITS;

    // dominant channel
    typedef logic [1:0] sector_t;
    localparam sector_t SECTOR_RED   = 2'd0;
    localparam sector_t SECTOR_GREEN = 2'd1;
    localparam sector_t SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [SREM_W-1:0] sat_rem;
        logic [CHAN_W-1:0] sat_div;
        logic [Q_W-1:0]    sat_q;
        logic [HREM_W-1:0] hue_rem;
        logic [HDIV_W-1:0] hue_div;
        logic [Q_W-1:0]    hue_q;
        logic              neg;
        sector_t           sector;
        logic [CHAN_W-1:0] value;
        logic              gray;
    } cell_data_t;

endpackage

// File: design/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// rgb pixel to hue, saturation and value through a chain of divider cells
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (lsb first)                     | tuser
//  s_axis   | in        | red[7:0] green[15:8] blue[23:16]      | -
//  m_axis   | out       | hue[14:0] sat[30:15] value[38:31] pad | gray
//
//  one beat per clock sustained while the output is not stalled, through
//  the input stage, one cell per quotient bit of saturation (17 cells),
//  and the output register; every stage has its own valid bit and holds
//  while the next cannot take its beat; gaps close up while output is stalled
//  reset clears only the valid bits; no state is kept between beats
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // red, green, blue from bit 0 up
    input  logic [rgbhsv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // hue, saturation, brightness from bit 0 up, zero padded
    output logic [rgbhsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // gray
    output logic [rgbhsv_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import rgbhsv_pkg::*;

    // chain links: index 0 is the front stage output, NUM_CELLS feeds the back
    cell_data_t        link_data  [NUM_CELLS+1];
    logic              link_valid [NUM_CELLS+1];
    logic              link_ready [NUM_CELLS+1];

    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [CHAN_W-1:0] brightness;
    logic              gray;

    rgbhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[CHAN_W-1:0]),
        .green     (s_axis_tdata[2*CHAN_W-1:CHAN_W]),
        .blue      (s_axis_tdata[3*CHAN_W-1:2*CHAN_W]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // one quotient bit of each division per cell, msb first
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        rgbhsv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    rgbhsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (link_valid[NUM_CELLS]),
        .in_ready   (link_ready[NUM_CELLS]),
        .in_data    (link_data[NUM_CELLS]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .gray       (gray)
    );

    assign m_axis_tdata = OUT_TDATA_W'({brightness, saturation, hue});
    assign m_axis_tuser = OUT_TUSER_W'(gray);

endmodule

// File: design/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// max, min, delta, dominant sector and divider set-up, one register stage
// ----------------------------------------------------------------------------
module rgbhsv_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     red,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     blue,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rgbhsv_pkg::cell_data_t            out_data
);
    import rgbhsv_pkg::*;

    logic              valid_reg;
    cell_data_t        data_reg;
    cell_data_t        data_next;

    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] op_a;
    logic [CHAN_W-1:0] op_b;
    logic [CHAN_W-1:0] mag;
    sector_t           sector;

    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        delta = mx - mn;

        // tie order red, green, blue
        if (red == mx)
        begin
            sector = SECTOR_RED;
            op_a   = green;
            op_b   = blue;
        end
        else if (green == mx)
        begin
            sector = SECTOR_GREEN;
            op_a   = blue;
            op_b   = red;
        end
        else
        begin
            sector = SECTOR_BLUE;
            op_a   = red;
            op_b   = green;
        end
        mag = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

        data_next.sat_rem = {1'b0, delta};
        data_next.sat_div = mx;
        data_next.sat_q   = '0;
        data_next.hue_rem = HREM_W'(mag) * HREM_W'(SECTOR_DEG);
        data_next.hue_div = {delta, {(HUE_INT_BITS - 1){1'b0}}};
        data_next.hue_q   = '0;
        data_next.neg     = (op_a < op_b);
        data_next.sector  = sector;
        data_next.value   = mx;
        data_next.gray    = (32'(delta) < 32'(GRAY_LIMIT)) || (delta == '0);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rgbhsv_cell.sv
// ----------------------------------------------------------------------------
// rgbhsv_cell
// one restoring division step for saturation and for hue, one quotient bit each
// ----------------------------------------------------------------------------
module rgbhsv_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rgbhsv_pkg::cell_data_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rgbhsv_pkg::cell_data_t out_data
);
    import rgbhsv_pkg::*;

    logic              valid_reg;
    cell_data_t        data_reg;
    cell_data_t        data_next;

    logic              sat_ge;
    logic              hue_ge;
    logic [SREM_W-1:0] sat_sub;
    logic [HREM_W-1:0] hue_sub;

    always_comb
    begin
        sat_ge  = in_data.sat_rem >= {1'b0, in_data.sat_div};
        sat_sub = sat_ge ? (in_data.sat_rem - {1'b0, in_data.sat_div}) : in_data.sat_rem;
        hue_ge  = in_data.hue_rem >= {1'b0, in_data.hue_div};
        hue_sub = hue_ge ? (in_data.hue_rem - {1'b0, in_data.hue_div}) : in_data.hue_rem;

        data_next         = in_data;
        data_next.sat_rem = {sat_sub[SREM_W-2:0], 1'b0};
        data_next.sat_q   = {in_data.sat_q[Q_W-2:0], sat_ge};
        data_next.hue_rem = {hue_sub[HREM_W-2:0], 1'b0};
        data_next.hue_q   = {in_data.hue_q[Q_W-2:0], hue_ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rgbhsv_back.sv
// ----------------------------------------------------------------------------
// rgbhsv_back
// saturation clamp, hue sign, sector offset and wrap, gray zeroing, output register
// ----------------------------------------------------------------------------
module rgbhsv_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  rgbhsv_pkg::cell_data_t               in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]         hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]         saturation,
    output logic [rgbhsv_pkg::CHAN_W-1:0]        brightness,
    output logic                                 gray
);
    import rgbhsv_pkg::*;

    logic              valid_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [HUE_W-1:0]  hue_next;
    logic [SAT_W-1:0]  sat_reg;
    logic [SAT_W-1:0]  sat_next;
    logic [CHAN_W-1:0] value_reg;
    logic              gray_reg;

    logic [HQ_W-1:0]   quot;
    logic              rem_nz;
    logic [HUE_W-1:0]  base;
    logic [HUE_W-1:0]  mag;

    always_comb
    begin
        quot   = in_data.hue_q[Q_W-1 -: HQ_W];
        rem_nz = (|in_data.hue_rem) || (|in_data.hue_q[HUE_EXTRA-1:0]);

        case (in_data.sector)
            SECTOR_GREEN: base = HUE_W'(2 * SECTOR_UNITS);
            SECTOR_BLUE:  base = HUE_W'(4 * SECTOR_UNITS);
            default:      base = '0;
        endcase

        // floor of a negative quotient is minus its ceiling
        mag = HUE_W'(quot) + HUE_W'(rem_nz);

        if (!in_data.neg)
        begin
            hue_next = base + HUE_W'(quot);
        end
        else if (base >= mag)
        begin
            hue_next = base - mag;
        end
        else
        begin
            hue_next = base + HUE_W'(FULL_TURN) - mag;
        end

        sat_next = in_data.sat_q[Q_W-1] ? '1 : in_data.sat_q[SAT_W-1:0];

        if (in_data.gray)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = value_reg;
    assign gray       = gray_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= in_data.value;
            gray_reg  <= in_data.gray;
        end
    end

endmodule

// File: design/rgbhsv_checker.sv
// ----------------------------------------------------------------------------
// rgbhsv_port_checker
// port-level checks on the converter output stream
// ----------------------------------------------------------------------------
module rgbhsv_port_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [rgbhsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic [rgbhsv_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import rgbhsv_pkg::*;

    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  sat;
    logic [CHAN_W-1:0] value;

    assign hue   = m_axis_tdata[HUE_W-1:0];
    assign sat   = m_axis_tdata[HUE_W+SAT_W-1:HUE_W];
    assign value = m_axis_tdata[OUT_FIELDS_W-1:HUE_W+SAT_W];

    // stalled beat holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat changed while stalled");

    // gray pixels carry no hue and no saturation
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (hue == '0 && sat == '0))
        else $error("gray beat with nonzero hue or saturation");

    // hue stays inside one turn
    a_turn: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(hue) < 32'(FULL_TURN)))
        else $error("hue outside one turn");

    // a coloured pixel has a nonzero maximum and nonzero saturation
    a_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (value != '0 && sat != '0))
        else $error("coloured beat with zero value or saturation");

    // with the sink ready the whole chain moves, so the input is ready too
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input not ready while output is ready");

endmodule

bind rgb_to_hsv_converter_core rgbhsv_port_checker u_rgbhsv_checker (.*);
